@@ hw/rtl/ntoa_pkg.sv @@
// ----------------------------------------------------------------------------
// ntoa_pkg
// types, codes and character helpers shared by the formatter modules
// ----------------------------------------------------------------------------
package ntoa_pkg;

  typedef enum logic [1:0] {
    OpUdec    = 2'd0,
    OpSdec    = 2'd1,
    OpHexByte = 2'd2,
    OpHexWord = 2'd3
  } op_e;

  localparam int unsigned MagW  = 17;
  localparam int unsigned CharW = 7;

  localparam logic [CharW-1:0] CharMinus = 7'h2D;
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharAlpha = 7'h37;

  // weight index 0..4 selects 10000, 1000, 100, 10, 1
  localparam logic [2:0] WidxUnits = 3'd4;

  // one character to be formatted, with what is left of the item
  typedef struct packed {
    logic            hex;
    logic            sign;
    logic [MagW-1:0] val;
    logic [2:0]      widx;
    logic [2:0]      cnt;
  } desc_t;

  function automatic logic [CharW-1:0] glyph(input logic [3:0] nib);
    logic [CharW-1:0] g;
    if (nib < 4'd10) begin
      g = CharZero + CharW'(nib);
    end else begin
      g = CharAlpha + CharW'(nib);
    end
    return g;
  endfunction

  function automatic logic [MagW-1:0] weight(input logic [2:0] widx);
    logic [MagW-1:0] w;
    case (widx)
      3'd0:    w = 17'd10000;
      3'd1:    w = 17'd1000;
      3'd2:    w = 17'd100;
      3'd3:    w = 17'd10;
      default: w = 17'd1;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/ntoa_prep.sv @@
// ----------------------------------------------------------------------------
// ntoa_prep
// input register: takes a transaction and stores its first character descriptor
// ----------------------------------------------------------------------------
module ntoa_prep (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,  // value
  input  logic [1:0]             s_axis_tuser,  // opcode
  output logic                   valid_o,
  output ntoa_pkg::desc_t        desc_o,
  input  logic                   take_i
);

  logic              valid_q, valid_d;
  ntoa_pkg::desc_t   desc_q, desc_d;
  logic              neg;
  logic [16:0]       mag;
  logic [2:0]        ndig;
  logic              accept;

  assign s_axis_tready = !valid_q || take_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    neg  = (s_axis_tuser == ntoa_pkg::OpSdec) && s_axis_tdata[15];
    mag  = neg ? (17'h10000 - {1'b0, s_axis_tdata}) : {1'b0, s_axis_tdata};
    ndig = 3'd1 + 3'(mag >= 17'd10) + 3'(mag >= 17'd100) + 3'(mag >= 17'd1000)
         + 3'(mag >= 17'd10000);
    desc_d = '0;
    case (s_axis_tuser)
      ntoa_pkg::OpHexByte: begin
        desc_d.hex = 1'b1;
        desc_d.val = {1'b0, s_axis_tdata[7:0], 8'h00};
        desc_d.cnt = 3'd2;
      end
      ntoa_pkg::OpHexWord: begin
        desc_d.hex = 1'b1;
        desc_d.val = {1'b0, s_axis_tdata};
        desc_d.cnt = 3'd4;
      end
      default: begin
        desc_d.sign = neg;
        desc_d.val  = mag;
        desc_d.widx = 3'd5 - ndig;
        desc_d.cnt  = ndig + 3'(neg);
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

  assign valid_o = valid_q;
  assign desc_o  = desc_q;

endmodule

@@ hw/rtl/ntoa_emit.sv @@
// ----------------------------------------------------------------------------
// ntoa_emit
// character engine: one character per unstalled cycle into the result register
// ----------------------------------------------------------------------------
module ntoa_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  ntoa_pkg::desc_t        desc_i,
  output logic                   take_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,  // ascii_char, zero bit
  output logic                   m_axis_tlast
);

  logic              busy_q, busy_d;
  ntoa_pkg::desc_t   st_q, st_d;
  logic              ov_q, ov_d;
  logic [6:0]        och_q, och_d;
  logic              olast_q, olast_d;

  ntoa_pkg::desc_t   cur, nxt;
  logic              have, adv;
  logic [16:0]       w;
  logic [16:0]       mult [10];
  logic [3:0]        dig;
  logic [6:0]        ch;

  assign have   = busy_q || valid_i;
  assign adv    = !ov_q || m_axis_tready;
  assign take_o = adv && !busy_q && valid_i;
  assign cur    = busy_q ? st_q : desc_i;

  always_comb begin
    w = ntoa_pkg::weight(cur.widx);
    mult[0] = '0;
    dig = '0;
    for (int k = 1; k < 10; k++) begin
      mult[k] = 17'(w * 17'(k));
      dig = dig + 4'(cur.val >= mult[k]);
    end
  end

  always_comb begin
    nxt     = cur;
    nxt.cnt = cur.cnt - 3'd1;
    if (cur.sign) begin
      ch       = ntoa_pkg::CharMinus;
      nxt.sign = 1'b0;
    end else if (cur.hex) begin
      ch      = ntoa_pkg::glyph(cur.val[15:12]);
      nxt.val = {1'b0, cur.val[11:0], 4'h0};
    end else begin
      ch       = ntoa_pkg::glyph(dig);
      nxt.val  = cur.val - mult[dig];
      nxt.widx = (cur.widx == ntoa_pkg::WidxUnits) ? cur.widx : cur.widx + 3'd1;
    end
  end

  always_comb begin
    busy_d  = busy_q;
    st_d    = st_q;
    ov_d    = ov_q;
    och_d   = och_q;
    olast_d = olast_q;
    if (adv) begin
      ov_d = have;
      if (have) begin
        och_d   = ch;
        olast_d = (cur.cnt == 3'd1);
        busy_d  = (cur.cnt != 3'd1);
        st_d    = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    och_q   <= och_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, och_q};
  assign m_axis_tlast  = olast_q;

endmodule

@@ hw/rtl/number_to_ascii_formatter_top.sv @@
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_top
// prints a 16-bit value as ascii decimal or hex characters, one per transaction
// first character: through the input register, then the result register
// throughput: one character per cycle unless m_axis_tready stalls the output;
//   an item of 1 to 6 characters is taken only when the one before is done
// reset: asynchronous, active low; clears input and result valid and busy flags
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // value
  input  logic [1:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // ascii_char, zero bit
  output logic        m_axis_tlast    // last
);

  logic            p_valid;
  logic            p_take;
  ntoa_pkg::desc_t p_desc;

  ntoa_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .valid_o       (p_valid),
    .desc_o        (p_desc),
    .take_i        (p_take)
  );

  ntoa_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (p_valid),
    .desc_i        (p_desc),
    .take_o        (p_take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
